>>> sv/atomic_memory_op_unit_top_defines.svh
// Assertion macros shared by the atomic memory operation unit.
// Used by the controller and datapath; expects i_clk and i_rst_n in scope.
`ifndef ATOMIC_MEMORY_OP_UNIT_TOP_DEFINES_SVH
`define ATOMIC_MEMORY_OP_UNIT_TOP_DEFINES_SVH

// Checked on every clock edge, off while reset is held.
`define AMO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AMO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/amo_pkg.sv
// Shared types, constants and helper functions of the atomic memory operation unit.
// No dependencies.
package amo_pkg;

    // Memory geometry
    localparam int MEM_WORDS   = 256;
    localparam int AMO_IDX_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int AMO_ADDR_W  = 11;
    localparam int AMO_WSEL_W  = AMO_ADDR_W - 3;          // word field of a byte address
    localparam int AMO_WSEL_N  = 1 << AMO_WSEL_W;
    localparam int AMO_DATA_W  = 64;

    // Operation codes
    typedef enum logic [3:0] {
        CMD_LOAD  = 4'd0,
        CMD_STORE = 4'd1,
        CMD_XCHG  = 4'd2,
        CMD_ADD   = 4'd3,
        CMD_SUB   = 4'd4,
        CMD_OR    = 4'd5,
        CMD_XOR   = 4'd6,
        CMD_AND   = 4'd7,
        CMD_NAND  = 4'd8,
        CMD_CAS   = 4'd9
    } t_amo_op;

    // Access size codes (log2 of bytes)
    typedef enum logic [1:0] {
        SZ_1B = 2'd0,
        SZ_2B = 2'd1,
        SZ_4B = 2'd2,
        SZ_8B = 2'd3
    } t_amo_size;

    // Controller to datapath commands
    typedef struct packed {
        logic                 capture;   // latch request, launch RAM read
        logic                 exec;      // modify, write back, load result
        logic                 clr_en;    // clearing pass write
        logic [AMO_IDX_W-1:0] clr_idx;
    } t_amo_ctl;

    // Word field of the address folded into the memory depth
    typedef logic [AMO_WSEL_N-1:0][AMO_IDX_W-1:0] t_idx_tbl;

    function automatic t_idx_tbl f_idx_table();
        t_idx_tbl tbl;
        for (int i = 0; i < AMO_WSEL_N; i++) begin
            tbl[i] = AMO_IDX_W'(i % MEM_WORDS);
        end
        return tbl;
    endfunction

    localparam t_idx_tbl IDX_TBL = f_idx_table();

    // Lane mask for an access size
    function automatic logic [AMO_DATA_W-1:0] f_lane_mask(input logic [1:0] size);
        logic [AMO_DATA_W-1:0] m;
        case (size)
            SZ_1B:   m = 64'h0000_0000_0000_00FF;
            SZ_2B:   m = 64'h0000_0000_0000_FFFF;
            SZ_4B:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Address not a multiple of the access size
    function automatic logic f_misaligned(input logic [2:0] low, input logic [1:0] size);
        logic bad;
        case (size)
            SZ_1B:   bad = 1'b0;
            SZ_2B:   bad = low[0];
            SZ_4B:   bad = |low[1:0];
            default: bad = |low;
        endcase
        return bad;
    endfunction

endpackage

>>> sv/amo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module amo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/amo_dp.sv
// Datapath of the atomic memory operation unit: request latch, word RAM,
// lane extract, operation ALU, write-back merge and result register. Uses amo_pkg, amo_ram.
`include "atomic_memory_op_unit_top_defines.svh"

module amo_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  amo_pkg::t_amo_ctl             i_ctl,
    input  logic [3:0]                    i_cmd,
    input  logic [amo_pkg::AMO_ADDR_W-1:0] i_byte_addr,
    input  logic [1:0]                    i_access_size,
    input  logic [63:0]                   i_operand,
    input  logic [63:0]                   i_compare_value,
    input  logic                          i_return_new,
    output logic [63:0]                   o_read_data,
    output logic                          o_swap_done,
    output logic                          o_align_error
);
    import amo_pkg::*;

    // Latched request
    logic [3:0]            r_cmd;
    logic [AMO_IDX_W-1:0]  r_idx;
    logic [2:0]            r_off;
    logic [63:0]           r_mask;
    logic [63:0]           r_opnd;
    logic [63:0]           r_cmpv;
    logic                  r_ret_new;
    logic                  r_misal;

    // Result register
    logic [63:0]           r_read_data;
    logic                  r_swap_done;
    logic                  r_align_error;

    logic [AMO_IDX_W-1:0]  rd_idx;
    logic [63:0]           in_mask;
    logic [63:0]           word;
    logic [5:0]            shamt;
    logic [63:0]           oldv;
    logic [63:0]           newv;
    logic                  wr_lane;
    logic                  cas_hit;
    logic [63:0]           merged;
    logic                  ram_we;
    logic [AMO_IDX_W-1:0]  ram_waddr;
    logic [63:0]           ram_wdata;

    assign rd_idx  = IDX_TBL[i_byte_addr[AMO_ADDR_W-1:3]];
    assign in_mask = f_lane_mask(i_access_size);

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd     <= i_cmd;
            r_idx     <= rd_idx;
            r_off     <= i_byte_addr[2:0];
            r_mask    <= in_mask;
            r_opnd    <= i_operand & in_mask;
            r_cmpv    <= i_compare_value & in_mask;
            r_ret_new <= i_return_new;
            r_misal   <= f_misaligned(i_byte_addr[2:0], i_access_size);
        end
    end

    // Word memory
    amo_ram #(
        .WIDTH (AMO_DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.capture),
        .i_raddr (rd_idx),
        .o_rdata (word)
    );

    // Lane extract
    assign shamt   = {r_off, 3'b000};
    assign oldv    = (word >> shamt) & r_mask;
    assign cas_hit = (oldv == r_cmpv);

    // Operation ALU
    always_comb begin
        newv    = oldv;
        wr_lane = 1'b1;
        case (r_cmd)
            CMD_STORE: newv = r_opnd;
            CMD_XCHG:  newv = r_opnd;
            CMD_ADD:   newv = (oldv + r_opnd) & r_mask;
            CMD_SUB:   newv = (oldv - r_opnd) & r_mask;
            CMD_OR:    newv = oldv | r_opnd;
            CMD_XOR:   newv = oldv ^ r_opnd;
            CMD_AND:   newv = oldv & r_opnd;
            CMD_NAND:  newv = ~(oldv & r_opnd) & r_mask;
            CMD_CAS: begin
                newv    = cas_hit ? r_opnd : oldv;
                wr_lane = cas_hit;
            end
            default: begin
                // load and unused codes: read only
                newv    = oldv;
                wr_lane = 1'b0;
            end
        endcase
    end

    // Write-back merge; the clearing pass takes the port after reset
    assign merged    = (word & ~(r_mask << shamt)) | (newv << shamt);
    assign ram_we    = i_ctl.clr_en | (i_ctl.exec & wr_lane & ~r_misal);
    assign ram_waddr = i_ctl.clr_en ? i_ctl.clr_idx : r_idx;
    assign ram_wdata = i_ctl.clr_en ? '0 : merged;

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            if (r_misal) begin
                r_read_data   <= '0;
                r_swap_done   <= 1'b0;
                r_align_error <= 1'b1;
            end else begin
                r_read_data   <= r_ret_new ? newv : oldv;
                r_swap_done   <= (r_cmd == CMD_CAS) && cas_hit;
                r_align_error <= 1'b0;
            end
        end
    end

    assign o_read_data   = r_read_data;
    assign o_swap_done   = r_swap_done;
    assign o_align_error = r_align_error;

    // A misaligned request never touches memory
    `AMO_ASSERT(a_misal_no_write, (i_ctl.exec && r_misal) |-> !ram_we, "misaligned request wrote memory")

endmodule

>>> sv/amo_ctrl.sv
// Controller of the atomic memory operation unit: clearing pass, request
// sequencing and result valid. Uses amo_pkg.
`include "atomic_memory_op_unit_top_defines.svh"

module amo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output amo_pkg::t_amo_ctl o_ctl
);
    import amo_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state               r_state;
    logic [AMO_IDX_W-1:0] r_clr_idx;
    logic                 r_out_valid;

    logic capture;
    logic exec;
    logic out_take;

    // Handshake decode
    assign capture  = (r_state == ST_IDLE) && i_in_valid;
    assign exec     = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign out_take = r_out_valid && i_out_ready;

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == AMO_IDX_W'(MEM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (capture) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase

            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_ctl.capture = capture;
    assign o_ctl.exec    = exec;
    assign o_ctl.clr_en  = (r_state == ST_CLEAR);
    assign o_ctl.clr_idx = r_clr_idx;

    // Every accepted item is executed on the following cycle or held for it
    `AMO_ASSERT(a_capture_to_exec, capture |=> (r_state == ST_EXEC), "accepted item not executed")
    // A result is produced only when the output register is free or draining
    `AMO_ASSERT(a_exec_no_overwrite, exec |-> (!r_out_valid || i_out_ready), "result overwritten")
    // Executing always leaves a valid result behind
    `AMO_ASSERT(a_exec_sets_valid, exec |=> r_out_valid, "result lost after execute")
    // No request work while the memory is being cleared
    `AMO_ASSERT_ALWAYS(a_clear_quiet, o_ctl.clr_en |-> (!capture && !exec), "request during clear")

endmodule

>>> sv/atomic_memory_op_unit_top.sv
// Atomic memory operation unit: load, store, exchange, fetch-and-op and
// compare-and-swap on 1, 2, 4 or 8 byte little-endian lanes of a 256 x 64-bit
// word memory. After reset the unit clears the memory, one word per cycle,
// with o_in_ready low. Each item then passes through an accept cycle, which
// launches the read of the single word RAM, and an execute step, which modifies
// the lane and writes the word back; a new item is taken only once the last one
// has been written back. The result sits in an output register; if it has not
// been taken, the next item waits in the execute step until the register frees.
// Misaligned addresses return align_error with memory untouched.
// Depends on amo_pkg, amo_ctrl, amo_dp, amo_ram.
module atomic_memory_op_unit_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [3:0]                      i_cmd,
    input  logic [amo_pkg::AMO_ADDR_W-1:0]  i_byte_addr,
    input  logic [1:0]                      i_access_size,
    input  logic [63:0]                     i_operand,
    input  logic [63:0]                     i_compare_value,
    input  logic                            i_return_new,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [63:0]                     o_read_data,
    output logic                            o_swap_done,
    output logic                            o_align_error
);
    import amo_pkg::*;

    t_amo_ctl ctl;

    // Sequencer
    amo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    // Memory and read-modify-write datapath
    amo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cmd           (i_cmd),
        .i_byte_addr     (i_byte_addr),
        .i_access_size   (i_access_size),
        .i_operand       (i_operand),
        .i_compare_value (i_compare_value),
        .i_return_new    (i_return_new),
        .o_read_data     (o_read_data),
        .o_swap_done     (o_swap_done),
        .o_align_error   (o_align_error)
    );

endmodule

>>> dv/tb_atomic_memory_op_unit_top.sv
// Testbench for atomic_memory_op_unit_top: random and directed atomic requests
// checked against a scoreboard that keeps its own copy of the word memory.
// Depends on amo_pkg and the atomic_memory_op_unit_top RTL.
`timescale 1ns / 1ps

module tb_atomic_memory_op_unit_top;
    import amo_pkg::*;

    // Codes outside the defined operation set; the block treats them as loads
    localparam logic [3:0] CMD_SPARE_LO = 4'd10;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    localparam int N_RANDOM   = 1080;
    localparam int HOLD_CYC   = 150;
    localparam int DRAIN_CYC  = 16;

    typedef struct {
        logic [3:0]            cmd;
        logic [AMO_ADDR_W-1:0] addr;
        logic [1:0]            size;
        logic [63:0]           opnd;
        logic [63:0]           cmpv;
        logic                  ret_new;
    } t_amo_req;

    // Keeps a shadow of the word memory, predicts each reply and checks it
    class amo_scoreboard;
        typedef struct {
            logic [63:0] data;
            logic        swapped;
            logic        misaligned;
        } t_reply;

        logic [63:0] shadow_mem [MEM_WORDS];
        t_reply      pending_replies [$];
        int          mismatches;
        int          n_requests;
        int          n_replies;
        int          n_misaligned;
        int          n_swap_hits;
        int          n_spare;
        bit [9:0]    ops_seen;

        function new();
            foreach (shadow_mem[i]) shadow_mem[i] = '0;
            mismatches   = 0;
            n_requests   = 0;
            n_replies    = 0;
            n_misaligned = 0;
            n_swap_hits  = 0;
            n_spare      = 0;
            ops_seen     = '0;
        endfunction

        function logic [63:0] lane_bits(logic [1:0] size);
            if (size == SZ_8B) return '1;
            return (64'd1 << (8 << size)) - 64'd1;
        endfunction

        function int word_of(logic [AMO_ADDR_W-1:0] addr);
            return int'(addr >> 3) % MEM_WORDS;
        endfunction

        // Current lane contents, used to build matching compare values
        function logic [63:0] peek_lane(logic [AMO_ADDR_W-1:0] addr, logic [1:0] size);
            return (shadow_mem[word_of(addr)] >> (int'(addr[2:0]) * 8)) & lane_bits(size);
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Apply one accepted request to the shadow memory and queue its reply
        function void apply_request(t_amo_req req);
            logic [63:0] mask;
            logic [63:0] opnd;
            logic [63:0] cmpv;
            logic [63:0] oldv;
            logic [63:0] newv;
            int          idx;
            int          shift;
            bit          wr;
            t_reply      rep;

            mask  = lane_bits(req.size);
            opnd  = req.opnd & mask;
            cmpv  = req.cmpv & mask;
            n_requests++;
            if (req.cmd <= CMD_CAS) ops_seen[req.cmd] = 1'b1;
            else n_spare++;

            rep.swapped    = 1'b0;
            rep.misaligned = 1'b0;
            if ((int'(req.addr[2:0]) & ((1 << req.size) - 1)) != 0) begin
                rep.data       = '0;
                rep.misaligned = 1'b1;
                n_misaligned++;
                pending_replies.push_back(rep);
                return;
            end

            idx   = word_of(req.addr);
            shift = int'(req.addr[2:0]) * 8;
            oldv  = (shadow_mem[idx] >> shift) & mask;
            wr    = 1'b1;
            case (req.cmd)
                CMD_STORE, CMD_XCHG: newv = opnd;
                CMD_ADD:  newv = (oldv + opnd) & mask;
                CMD_SUB:  newv = (oldv - opnd) & mask;
                CMD_OR:   newv = oldv | opnd;
                CMD_XOR:  newv = oldv ^ opnd;
                CMD_AND:  newv = oldv & opnd;
                CMD_NAND: newv = ~(oldv & opnd) & mask;
                CMD_CAS: begin
                    if (oldv == cmpv) begin
                        newv        = opnd;
                        rep.swapped = 1'b1;
                        n_swap_hits++;
                    end else begin
                        newv = oldv;
                        wr   = 1'b0;
                    end
                end
                default: begin
                    // load and the spare codes
                    newv = oldv;
                    wr   = 1'b0;
                end
            endcase

            if (wr)
                shadow_mem[idx] = (shadow_mem[idx] & ~(mask << shift)) | (newv << shift);
            rep.data = req.ret_new ? newv : oldv;
            pending_replies.push_back(rep);
        endfunction

        // Compare one reply from the block with the oldest prediction
        function void match_reply(logic [63:0] data, logic swapped, logic misaligned);
            t_reply exp_rep;
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: read_data %h", data);
                mismatches++;
                return;
            end
            exp_rep = pending_replies.pop_front();
            n_replies++;
            if (data !== exp_rep.data) begin
                $error("read_data mismatch: expected %h, actual %h", exp_rep.data, data);
                mismatches++;
            end
            if (swapped !== exp_rep.swapped) begin
                $error("swap_done mismatch: expected %b, actual %b", exp_rep.swapped, swapped);
                mismatches++;
            end
            if (misaligned !== exp_rep.misaligned) begin
                $error("align_error mismatch: expected %b, actual %b",
                       exp_rep.misaligned, misaligned);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [3:0]            i_cmd;
    logic [AMO_ADDR_W-1:0] i_byte_addr;
    logic [1:0]            i_access_size;
    logic [63:0]           i_operand;
    logic [63:0]           i_compare_value;
    logic                  i_return_new;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [63:0]           o_read_data;
    logic                  o_swap_done;
    logic                  o_align_error;

    amo_scoreboard sb;
    bit            hold_off_req;
    int            n_holds;
    logic [7:0]    hot_words [8];

    atomic_memory_op_unit_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_byte_addr     (i_byte_addr),
        .i_access_size   (i_access_size),
        .i_operand       (i_operand),
        .i_compare_value (i_compare_value),
        .i_return_new    (i_return_new),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_swap_done     (o_swap_done),
        .o_align_error   (o_align_error)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Present one item at the falling edge and hold it until accepted
    task automatic drive_item(t_amo_req req);
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_cmd           = req.cmd;
        i_byte_addr     = req.addr;
        i_access_size   = req.size;
        i_operand       = req.opnd;
        i_compare_value = req.cmpv;
        i_return_new    = req.ret_new;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.apply_request(req);
    endtask

    task automatic issue(logic [3:0] cmd, logic [AMO_ADDR_W-1:0] addr, logic [1:0] size,
                         logic [63:0] opnd, logic [63:0] cmpv, logic ret_new);
        t_amo_req req;
        req.cmd     = cmd;
        req.addr    = addr;
        req.size    = size;
        req.opnd    = opnd;
        req.cmpv    = cmpv;
        req.ret_new = ret_new;
        drive_item(req);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending until every outstanding reply has been checked
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Mostly aligned accesses to a few hot words so RMW chains and CAS hits build up
    function automatic t_amo_req make_random_req();
        t_amo_req req;
        logic [7:0] word;
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 4) req.cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else          req.cmd = 4'($urandom_range(0, CMD_CAS));
        req.size = 2'($urandom_range(0, 3));

        if ($urandom_range(0, 99) < 80) begin
            word     = hot_words[$urandom_range(0, 7)];
            req.addr = {word, 3'($urandom_range(0, 7))};
        end else begin
            req.addr = AMO_ADDR_W'($urandom_range(0, (1 << AMO_ADDR_W) - 1));
        end
        if ($urandom_range(0, 99) < 85)
            req.addr = req.addr & ~AMO_ADDR_W'((1 << req.size) - 1);

        req.opnd    = rand_word();
        req.ret_new = 1'($urandom_range(0, 1));
        // Half of the swaps compare against the live lane, high bits left as noise
        if (req.cmd == CMD_CAS && $urandom_range(0, 1) == 1)
            req.cmpv = sb.peek_lane(req.addr, req.size)
                     | (rand_word() & ~sb.lane_bits(req.size));
        else
            req.cmpv = rand_word();
        return req;
    endfunction

    // Reply side: check at the rising edge, set ready at the falling edge
    initial begin
        int hold_left;
        int mode_left;
        int period;
        int duty;
        int phase;

        hold_left   = 0;
        mode_left   = 0;
        period      = 1;
        duty        = 0;
        phase       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
                sb.match_reply(o_read_data, o_swap_done, o_align_error);
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYC;
                n_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                // stall pattern: ready for the tail of each period, duty 0 means no stalls
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 96);
                    period    = $urandom_range(1, 6);
                    duty      = $urandom_range(0, period - 1);
                    phase     = 0;
                end
                mode_left--;
                i_out_ready = (phase >= duty);
                phase       = (phase + 1) % period;
            end
        end
    end

    // Stimulus
    initial begin
        int burst_left;
        t_amo_req req;

        sb              = new();
        hold_off_req    = 1'b0;
        n_holds         = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_LOAD;
        i_byte_addr     = '0;
        i_access_size   = SZ_1B;
        i_operand       = '0;
        i_compare_value = '0;
        i_return_new    = 1'b0;

        hot_words[0] = 8'd0;
        hot_words[1] = 8'd255;
        foreach (hot_words[i])
            if (i > 1) hot_words[i] = 8'($urandom_range(0, 255));

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each operation, misaligned, failed swap, spare codes
        issue(CMD_LOAD,  11'h000, SZ_8B, '1, '0, 1'b0);
        issue(CMD_STORE, 11'h7F8, SZ_8B, '1, '0, 1'b1);
        issue(CMD_LOAD,  11'h7FF, SZ_1B, '0, '0, 1'b1);
        issue(CMD_ADD,   11'h7FF, SZ_1B, 64'd1, '0, 1'b1);
        issue(CMD_SUB,   11'h000, SZ_2B, 64'd1, '0, 1'b1);
        issue(CMD_XCHG,  11'h7FC, SZ_4B, 64'h1234_5678_9ABC_DEF0, '0, 1'b0);
        issue(CMD_OR,    11'h001, SZ_1B, 64'hA5, '0, 1'b1);
        issue(CMD_XOR,   11'h002, SZ_2B, 64'hFFFF, '0, 1'b0);
        issue(CMD_AND,   11'h7F8, SZ_8B, 64'h0F0F_0F0F_0F0F_0F0F, '0, 1'b1);
        issue(CMD_NAND,  11'h7F8, SZ_4B, '1, '0, 1'b1);
        issue(CMD_CAS,   11'h7F8, SZ_8B, 64'd5, ~sb.peek_lane(11'h7F8, SZ_8B), 1'b1);
        issue(CMD_CAS,   11'h7F8, SZ_8B, 64'h0123_4567_89AB_CDEF,
              sb.peek_lane(11'h7F8, SZ_8B), 1'b0);
        issue(CMD_CAS,   11'h7FF, SZ_1B, 64'h5A,
              sb.peek_lane(11'h7FF, SZ_1B) | 64'hFFFF_FFFF_FFFF_FF00, 1'b1);
        issue(CMD_STORE, 11'h001, SZ_2B, '1, '0, 1'b1);
        issue(CMD_CAS,   11'h006, SZ_4B, '1, '0, 1'b1);
        issue(CMD_ADD,   11'h7FC, SZ_8B, '1, '0, 1'b0);
        issue(CMD_LOAD,  11'h000, SZ_8B, '0, '0, 1'b0);
        issue(CMD_SPARE_LO, 11'h7F8, SZ_8B, '1, '1, 1'b1);
        issue(CMD_SPARE_HI, 11'h000, SZ_1B, 64'h77, '0, 1'b1);
        issue(CMD_STORE, 11'h400, SZ_1B, 64'hFFFF_FFFF_FFFF_FF80, '0, 1'b1);
        issue(CMD_LOAD,  11'h400, SZ_8B, '0, '0, 1'b1);
        issue(CMD_ADD,   11'h400, SZ_8B, '1, '0, 1'b1);
        issue(CMD_SUB,   11'h404, SZ_4B, 64'h8000_0000, '0, 1'b0);
        issue(CMD_STORE, 11'h000, SZ_8B, '0, '0, 1'b0);
        drain_all();

        // Random bursts with random gaps
        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            // long receiver hold-off while items keep coming
            if (n == 300 || n == 800) hold_off_req = 1'b1;
            if (n == 600) drain_all();
            req = make_random_req();
            drive_item(req);
        end

        drain_all();
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d requests: all ten operations %s, %0d misaligned, %0d spare codes,",
                 sb.n_requests, (sb.ops_seen == '1) ? "seen" : "NOT all seen",
                 sb.n_misaligned, sb.n_spare);
        $display("%0d successful swaps, %0d replies checked, %0d long receiver hold-offs.",
                 sb.n_swap_hits, sb.n_replies, n_holds);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
